### src/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

   localparam int OPW = 36;
   localparam int DW = 40;
   localparam int AW = 34;
   localparam int SQW = 58;
   localparam int SQRT_STEPS = 29;
   localparam int ATAN_TAB_LEN = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int LANES = 3;

   localparam logic signed [OPW-1:0] ONE_Q28 = OPW'(64'sd268435456);
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [16:0] ROLL_LIM = 17'sd25736;
   localparam logic signed [16:0] PITCH_LIM = 17'sd12868;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [AW-1:0] ang;
      logic zero;
   } lane_type;

   typedef struct packed {
      logic signed [OPW-1:0] t0;
      logic signed [OPW-1:0] t1;
      logic signed [OPW-1:0] t3;
      logic signed [OPW-1:0] t4;
      logic signed [29:0] t2;
   } side_type;

   function automatic logic signed [AW-1:0] atan_entry(input int idx);
      logic signed [AW-1:0] r;
      case (idx)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         10: r = 34'sd1048576;
         11: r = 34'sd524288;
         12: r = 34'sd262144;
         13: r = 34'sd131072;
         14: r = 34'sd65536;
         15: r = 34'sd32768;
         16: r = 34'sd16384;
         17: r = 34'sd8192;
         18: r = 34'sd4096;
         19: r = 34'sd2048;
         20: r = 34'sd1024;
         21: r = 34'sd512;
         22: r = 34'sd256;
         23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### src/q2e_sqrt_cell.sv
`default_nettype none
module q2e_sqrt_cell #(
   parameter int K = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic valid_in,
   input wire logic [q2e_pkg::SQW-1:0] rem_in,
   input wire logic [q2e_pkg::SQW-1:0] res_in,
   input wire q2e_pkg::side_type side_in,
   output logic valid_out,
   output logic [q2e_pkg::SQW-1:0] rem_out,
   output logic [q2e_pkg::SQW-1:0] res_out,
   output q2e_pkg::side_type side_out
);
   import q2e_pkg::*;

   localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * K);

   logic valid_ff;
   logic [SQW-1:0] rem_ff, rem_in_c;
   logic [SQW-1:0] res_ff, res_in_c;
   side_type side_ff;
   logic [SQW-1:0] trial;

   always_comb begin
      trial = res_in + BITV;
      if (rem_in >= trial) begin
         rem_in_c = rem_in - trial;
         res_in_c = (res_in >> 1) + BITV;
      end else begin
         rem_in_c = rem_in;
         res_in_c = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in_c;
         res_ff <= res_in_c;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out = rem_ff;
   assign res_out = res_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

### src/q2e_cordic_cell.sv
`default_nettype none
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic adv,
   input wire logic valid_in,
   input wire q2e_pkg::lane_type [q2e_pkg::LANES-1:0] lane_in,
   output logic valid_out,
   output q2e_pkg::lane_type [q2e_pkg::LANES-1:0] lane_out
);
   import q2e_pkg::*;

   localparam logic signed [AW-1:0] ATAN = atan_entry(STEP);

   logic valid_ff;
   lane_type [LANES-1:0] lane_ff, lane_in_c;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_in_c[i].zero = lane_in[i].zero;
         if (!lane_in[i].y[DW-1]) begin
            lane_in_c[i].x = lane_in[i].x + (lane_in[i].y >>> STEP);
            lane_in_c[i].y = lane_in[i].y - (lane_in[i].x >>> STEP);
            lane_in_c[i].ang = lane_in[i].ang + ATAN;
         end else begin
            lane_in_c[i].x = lane_in[i].x - (lane_in[i].y >>> STEP);
            lane_in_c[i].y = lane_in[i].y + (lane_in[i].x >>> STEP);
            lane_in_c[i].ang = lane_in[i].ang - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out = lane_ff;
endmodule
`default_nettype wire

### src/quaternion_to_euler.sv
// path: product, sum, square and radicand registers, 29 square root cells, a
// prerotation register, min(CORDIC_STEPS, 24) rotation cells, output register
// throughput: one item per cycle, as each cell hands its item on whenever the
// pipeline moves; it holds while a result waits untaken at the output register
// reset: synchronous, active high; clears all valid bits, no result pending
`default_nettype none
module quaternion_to_euler #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic signed [15:0] req_quat_w,
   input wire logic signed [15:0] req_quat_x,
   input wire logic signed [15:0] req_quat_y,
   input wire logic signed [15:0] req_quat_z,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);
   import q2e_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;

   logic adv;

   // products
   logic v1_ff;
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wy_ff;
   logic signed [31:0] p_zx_ff, p_wz_ff, p_xy_ff, p_zz_ff;

   // sums
   logic v2_ff;
   side_type s2_ff, s2_in;
   logic signed [OPW-1:0] t2_raw;

   // square of pitch argument
   logic v3_ff;
   side_type s3_ff;
   logic signed [59:0] sq_full;
   logic [SQW-1:0] sq_ff;

   // radicand
   logic v4_ff;
   side_type s4_ff;
   logic [SQW-1:0] rad_ff;

   logic sq_v [SQRT_STEPS+1];
   logic [SQW-1:0] sq_rem [SQRT_STEPS+1];
   logic [SQW-1:0] sq_res [SQRT_STEPS+1];
   side_type sq_side [SQRT_STEPS+1];

   logic cd_v [NSTEPS+1];
   lane_type [LANES-1:0] cd_lane [NSTEPS+1];
   lane_type [LANES-1:0] pre_in;
   logic pre_v_ff;
   lane_type [LANES-1:0] pre_ff;

   logic rsp_valid_ff;
   logic signed [15:0] roll_ff, yaw_ff, roll_in, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;

   function automatic lane_type prerot(input logic signed [DW-1:0] y,
                                       input logic signed [DW-1:0] x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      if (x[DW-1]) begin
         if (!y[DW-1]) begin
            l.x = y;
            l.y = -x;
            l.ang = HALF_PI_Q30;
         end else begin
            l.x = -y;
            l.y = x;
            l.ang = -HALF_PI_Q30;
         end
      end else begin
         l.x = x;
         l.y = y;
         l.ang = '0;
      end
      return l;
   endfunction

   function automatic logic signed [16:0] to_q13(input logic signed [AW-1:0] a,
                                                  input logic signed [16:0] lim,
                                                  input logic zero);
      logic signed [AW-1:0] r;
      logic signed [16:0] q;
      r = a + 34'sd65536;
      q = r[AW-1:17];
      if (zero) begin
         q = '0;
      end else if (q > lim) begin
         q = lim;
      end else if (q < -lim) begin
         q = -lim;
      end
      return q;
   endfunction

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         pre_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         pre_v_ff <= sq_v[SQRT_STEPS];
         rsp_valid_ff <= cd_v[NSTEPS];
      end
   end

   always_comb begin
      s2_in.t0 = (OPW'(p_wx_ff) + OPW'(p_yz_ff)) <<< 1;
      s2_in.t1 = ONE_Q28 - ((OPW'(p_xx_ff) + OPW'(p_yy_ff)) <<< 1);
      s2_in.t3 = (OPW'(p_wz_ff) + OPW'(p_xy_ff)) <<< 1;
      s2_in.t4 = ONE_Q28 - ((OPW'(p_yy_ff) + OPW'(p_zz_ff)) <<< 1);
      t2_raw = (OPW'(p_wy_ff) - OPW'(p_zx_ff)) <<< 1;
      if (t2_raw > ONE_Q28) begin
         s2_in.t2 = 30'(ONE_Q28);
      end else if (t2_raw < -ONE_Q28) begin
         s2_in.t2 = 30'(-ONE_Q28);
      end else begin
         s2_in.t2 = 30'(t2_raw);
      end
   end

   assign sq_full = s2_ff.t2 * s2_ff.t2;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_wx_ff <= req_quat_w * req_quat_x;
         p_yz_ff <= req_quat_y * req_quat_z;
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         p_wy_ff <= req_quat_w * req_quat_y;
         p_zx_ff <= req_quat_z * req_quat_x;
         p_wz_ff <= req_quat_w * req_quat_z;
         p_xy_ff <= req_quat_x * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
         s2_ff <= s2_in;
         s3_ff <= s2_ff;
         sq_ff <= sq_full[SQW-1:0];
         s4_ff <= s3_ff;
         rad_ff <= (SQW'(1) << 56) - sq_ff;
         pre_ff <= pre_in;
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff <= yaw_in;
      end
   end

   assign sq_v[0] = v4_ff;
   assign sq_rem[0] = rad_ff;
   assign sq_res[0] = '0;
   assign sq_side[0] = s4_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      q2e_sqrt_cell #(
         .K(SQRT_STEPS - 1 - g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .valid_in(sq_v[g]),
         .rem_in(sq_rem[g]),
         .res_in(sq_res[g]),
         .side_in(sq_side[g]),
         .valid_out(sq_v[g+1]),
         .rem_out(sq_rem[g+1]),
         .res_out(sq_res[g+1]),
         .side_out(sq_side[g+1])
      );
   end

   always_comb begin
      pre_in[0] = prerot(DW'(sq_side[SQRT_STEPS].t0), DW'(sq_side[SQRT_STEPS].t1));
      pre_in[1] = prerot(DW'(sq_side[SQRT_STEPS].t2),
                         $signed(DW'(sq_res[SQRT_STEPS][28:0])));
      pre_in[2] = prerot(DW'(sq_side[SQRT_STEPS].t3), DW'(sq_side[SQRT_STEPS].t4));
   end

   assign cd_v[0] = pre_v_ff;
   assign cd_lane[0] = pre_ff;

   for (genvar g = 0; g < NSTEPS; g++) begin : g_cordic
      q2e_cordic_cell #(
         .STEP(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .valid_in(cd_v[g]),
         .lane_in(cd_lane[g]),
         .valid_out(cd_v[g+1]),
         .lane_out(cd_lane[g+1])
      );
   end

   always_comb begin
      logic signed [16:0] qr, qp, qy;
      qr = to_q13(cd_lane[NSTEPS][0].ang, ROLL_LIM, cd_lane[NSTEPS][0].zero);
      qp = to_q13(cd_lane[NSTEPS][1].ang, PITCH_LIM, cd_lane[NSTEPS][1].zero);
      qy = to_q13(cd_lane[NSTEPS][2].ang, ROLL_LIM, cd_lane[NSTEPS][2].zero);
      roll_in = qr[15:0];
      pitch_in = qp[14:0];
      yaw_in = qy[15:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_angle = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle = yaw_ff;
endmodule
`default_nettype wire
